[hw/rtl/fdm_pkg.sv]
// Package for the detector fault monitor: item and result types, op codes,
// register indexes, sequencer states and counter limits. No dependencies.
package fdm_pkg;

  localparam int unsigned MaxChannels = 8;
  localparam int unsigned LimitW      = 8;
  localparam int unsigned CfgW        = MaxChannels * LimitW;
  localparam int unsigned AlarmW      = 3 * MaxChannels;
  localparam int unsigned DivW        = 6;

  localparam logic [15:0] CountMax   = 16'hffff;
  localparam logic [7:0]  ErraticMax = 8'hff;
  localparam logic [15:0] SecPerMin  = 16'd60;

  localparam int unsigned FlagIdle     = 0;
  localparam int unsigned FlagPresence = 1;
  localparam int unsigned FlagErratic  = 2;

  typedef enum logic {
    OP_TICK    = 1'b0,
    OP_ERRATIC = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    REG_NO_ACTIVITY  = 2'd0,
    REG_MAX_PRESENCE = 2'd1,
    REG_ERRATIC      = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  typedef struct packed {
    logic       op;
    logic [7:0] valid_mask;
    logic       door_edge;
    logic [2:0] channel;
  } item_t;

  typedef struct packed {
    logic [AlarmW-1:0] alarm_bits;
    logic              door_alarm;
  } result_t;

  typedef struct packed {
    logic [15:0] presence;
    logic [15:0] idle;
    logic [7:0]  erratic;
  } entry_t;

endpackage

[hw/rtl/fdm_if.sv]
// Valid/ready channel interfaces for input and result transactions.
// Depends on fdm_pkg.
interface fdm_item_if;
  logic          valid;
  logic          ready;
  fdm_pkg::item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fdm_result_if;
  logic             valid;
  logic             ready;
  fdm_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/detector_fault_monitor.sv]
// Detector fault monitor top level: per-channel counter memory, sequencer,
// alarm flags and result register. Depends on fdm_pkg and fdm_if.

// A tick transaction walks the channel counter memory one entry per cycle
// through a single read/modify/write port, from the accept through one write
// per entry to the result load; an erratic event updates only its own
// channel's entry, and one for a channel at or above CHANNELS goes straight
// to the result load. The result register lets the next transaction start
// while the previous result waits. Counters come out of reset cleared
// through per-entry valid bits, with no clearing pass.
module detector_fault_monitor #(
  parameter int unsigned CHANNELS        = 8,
  parameter int unsigned TICKS_PER_CHECK = 60
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [fdm_pkg::CfgW-1:0]  cfg_data_i,
  fdm_item_if.sink                  item_i,
  fdm_result_if.source              result_o
);

  localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  fdm_pkg::state_e state_q, state_d;

  logic [fdm_pkg::CfgW-1:0] na_lim_q, pr_lim_q, er_lim_q;
  logic [fdm_pkg::DivW-1:0] div_q, div_d, div_inc;

  logic            op_q;
  logic [7:0]      mask_q;
  logic            door_q;
  logic            check_q, check_d;
  logic [CW-1:0]   idx_q, idx_d;

  fdm_pkg::entry_t mem [CHANNELS];
  logic [CHANNELS-1:0] ent_vld_q;
  fdm_pkg::entry_t rd_data_q;
  logic            rd_vld_q;
  logic            rd_en;
  logic [CW-1:0]   rd_addr;
  logic            mem_we;
  logic            in_acc;
  logic            chan_ok;
  logic            out_load;

  fdm_pkg::entry_t cur, nxt;
  logic [2:0]      flags_new;
  logic [CHANNELS-1:0][2:0] flags_q;
  logic [fdm_pkg::LimitW-1:0] na_lim, pr_lim, er_lim;

  logic             out_valid_q;
  fdm_pkg::result_t out_data_q;
  logic [fdm_pkg::AlarmW-1:0] alarm;

  assign item_i.ready    = (state_q == fdm_pkg::ST_IDLE);
  assign in_acc          = item_i.valid && item_i.ready;
  assign chan_ok         = ({1'b0, item_i.data.channel} < 4'(CHANNELS));
  assign result_o.valid  = out_valid_q;
  assign result_o.data   = out_data_q;

  // Minute divider
  assign div_inc = div_q + fdm_pkg::DivW'(1);

  always_comb begin
    div_d   = div_q;
    check_d = check_q;
    if (in_acc && (item_i.data.op == fdm_pkg::OP_TICK)) begin
      check_d = (div_inc >= fdm_pkg::DivW'(TICKS_PER_CHECK));
      div_d   = check_d ? '0 : div_inc;
    end
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    rd_en    = 1'b0;
    rd_addr  = idx_q;
    mem_we   = 1'b0;
    out_load = 1'b0;
    case (state_q)
      fdm_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (item_i.data.op == fdm_pkg::OP_TICK) begin
            idx_d   = '0;
            rd_en   = 1'b1;
            rd_addr = '0;
            state_d = fdm_pkg::ST_RUN;
          end else if (chan_ok) begin
            idx_d   = item_i.data.channel[CW-1:0];
            rd_en   = 1'b1;
            rd_addr = item_i.data.channel[CW-1:0];
            state_d = fdm_pkg::ST_RUN;
          end else begin
            state_d = fdm_pkg::ST_DONE;
          end
        end
      end
      fdm_pkg::ST_RUN: begin
        mem_we = 1'b1;
        if ((op_q == fdm_pkg::OP_TICK) && (idx_q != CW'(CHANNELS - 1))) begin
          idx_d   = idx_q + CW'(1);
          rd_en   = 1'b1;
          rd_addr = idx_q + CW'(1);
        end else begin
          state_d = fdm_pkg::ST_DONE;
        end
      end
      fdm_pkg::ST_DONE: begin
        if (!out_valid_q || result_o.ready) begin
          out_load = 1'b1;
          state_d  = fdm_pkg::ST_IDLE;
        end
      end
      default: state_d = fdm_pkg::ST_IDLE;
    endcase
  end

  // Entry update
  assign cur    = rd_vld_q ? rd_data_q : '0;
  assign na_lim = na_lim_q[8*idx_q +: 8];
  assign pr_lim = pr_lim_q[8*idx_q +: 8];
  assign er_lim = er_lim_q[8*idx_q +: 8];

  always_comb begin
    nxt       = cur;
    flags_new = flags_q[idx_q];
    if (op_q == fdm_pkg::OP_ERRATIC) begin
      if (cur.erratic != fdm_pkg::ErraticMax) nxt.erratic = cur.erratic + 8'd1;
    end else begin
      if (mask_q[idx_q]) begin
        if (cur.presence != fdm_pkg::CountMax) nxt.presence = cur.presence + 16'd1;
      end else begin
        if (cur.idle != fdm_pkg::CountMax) nxt.idle = cur.idle + 16'd1;
      end
      if (check_q) begin
        if (na_lim != '0) begin
          flags_new[fdm_pkg::FlagIdle] = (nxt.idle >= 16'(na_lim) * fdm_pkg::SecPerMin);
        end
        if (pr_lim != '0) begin
          flags_new[fdm_pkg::FlagPresence] =
            (nxt.presence >= 16'(pr_lim) * fdm_pkg::SecPerMin);
        end
        if (er_lim != '0) begin
          flags_new[fdm_pkg::FlagErratic] = (cur.erratic > er_lim);
        end
        nxt.erratic = '0;
      end
    end
  end

  always_comb begin
    alarm = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      alarm[3*c +: 3] = flags_q[c];
    end
  end

  // Counter memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[idx_q] <= nxt;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (mem_we) ent_vld_q[idx_q] <= 1'b1;
      if (rd_en) rd_vld_q <= ent_vld_q[rd_addr];
    end
  end

  // Control and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fdm_pkg::ST_IDLE;
      na_lim_q    <= '0;
      pr_lim_q    <= '0;
      er_lim_q    <= '0;
      div_q       <= '0;
      check_q     <= 1'b0;
      idx_q       <= '0;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      div_q   <= div_d;
      check_q <= check_d;
      idx_q   <= idx_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          fdm_pkg::REG_NO_ACTIVITY:  na_lim_q <= cfg_data_i;
          fdm_pkg::REG_MAX_PRESENCE: pr_lim_q <= cfg_data_i;
          fdm_pkg::REG_ERRATIC:      er_lim_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (mem_we) flags_q[idx_q] <= flags_new;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= item_i.data.op;
      mask_q <= item_i.data.valid_mask;
      door_q <= item_i.data.door_edge;
    end
    if (out_load) begin
      out_data_q.alarm_bits <= alarm;
      out_data_q.door_alarm <= (op_q == fdm_pkg::OP_TICK) ? door_q : 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_div_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_q < fdm_pkg::DivW'(TICKS_PER_CHECK))
    else $error("minute divider out of range");

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ({1'b0, idx_q} < (CW + 1)'(CHANNELS)))
    else $error("counter write beyond last channel");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !item_i.ready)
    else $error("input ready right after a transaction");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == fdm_pkg::ST_DONE))
    else $error("result valid without a finished transaction");
`endif

endmodule
